// ----- rtl/cse_pkg.sv -----
// shared types, widths and step table for the cubic spline evaluator
package cse_pkg;

    localparam int DEF_MAX_KNOTS = 16;
    localparam int ACC_W         = 136;  // signed working width of the numerator
    localparam int MUL_W         = 37;   // signed narrow multiplier operand
    localparam int PROD_W        = 70;   // 33 x 37 signed product
    localparam int DIV_W         = 36;   // divisor 6*|h|
    localparam int QUO_W         = 32;

    typedef struct packed {
        logic [31:0] g;
        logic [31:0] y;
        logic [31:0] x;
    } t_knot;

    typedef struct packed {
        logic       clear;     // start from an empty accumulator
        logic       from_acc;  // wide operand is the accumulator itself
        logic [2:0] nc;        // number of 32-bit chunks in the wide operand
        logic       sh32;      // product weighted by 2^32
    } t_mac_op;

    typedef enum logic [2:0] {
        ST_G0 = 3'd0,
        ST_G1 = 3'd1,
        ST_MB = 3'd2,
        ST_MA = 3'd3,
        ST_Y0 = 3'd4,
        ST_Y1 = 3'd5
    } t_step;

    function automatic t_mac_op step_op(input t_step s);
        t_mac_op o;
        o = '{clear: 1'b0, from_acc: 1'b0, nc: 3'd1, sh32: 1'b0};
        unique case (s)
            ST_G0: o.clear = 1'b1;
            ST_G1: o.clear = 1'b0;
            ST_MB: begin
                o.clear = 1'b1; o.from_acc = 1'b1; o.nc = 3'd3;
            end
            ST_MA: begin
                o.clear = 1'b1; o.from_acc = 1'b1; o.nc = 3'd4;
            end
            ST_Y0: o.sh32 = 1'b1;
            ST_Y1: o.sh32 = 1'b1;
            default: o.clear = 1'b1;
        endcase
        return o;
    endfunction

    function automatic t_step next_step(input t_step s);
        t_step n;
        unique case (s)
            ST_G0:   n = ST_G1;
            ST_G1:   n = ST_MB;
            ST_MB:   n = ST_MA;
            ST_MA:   n = ST_Y0;
            ST_Y0:   n = ST_Y1;
            default: n = ST_Y1;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/cse_mem.sv -----
// knot table: one write port, one registered read port
module cse_mem #(
    parameter int DEPTH = cse_pkg::DEF_MAX_KNOTS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  cse_pkg::t_knot           i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output cse_pkg::t_knot           o_rdata
);

    cse_pkg::t_knot mem [DEPTH];
    cse_pkg::t_knot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cse_mac.sv -----
// chunked multiply-accumulate: wide signed operand times narrow signed factor
module cse_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  cse_pkg::t_mac_op                i_op,
    input  logic [31:0]                     i_x,
    input  logic signed [cse_pkg::MUL_W-1:0] i_m,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [cse_pkg::ACC_W-1:0]       o_acc
);

    localparam int AW = cse_pkg::ACC_W;
    localparam int PW = cse_pkg::PROD_W;

    logic [AW-1:0]                  r_x;
    logic [AW-1:0]                  r_acc;
    logic signed [cse_pkg::MUL_W-1:0] r_m;
    logic [1:0]                     r_k;
    logic [2:0]                     r_nc;
    logic                           r_sh;
    logic                           r_issue;
    logic                           r_pv;
    logic                           r_plast;
    logic signed [PW-1:0]           r_p;
    logic [2:0]                     r_pk;
    logic                           r_done;

    logic [31:0]       chunk;
    logic              last_chunk;
    logic signed [32:0] xs;
    logic [AW-1:0]     pe;
    logic [AW-1:0]     pshift;

    always_comb begin
        case (r_k)
            2'd0:    chunk = r_x[31:0];
            2'd1:    chunk = r_x[63:32];
            2'd2:    chunk = r_x[95:64];
            default: chunk = r_x[127:96];
        endcase
        last_chunk = ({1'b0, r_k} == (r_nc - 3'd1));
        // only the top chunk carries the sign
        xs = {(last_chunk & chunk[31]), chunk};
        pe = {{(AW-PW){r_p[PW-1]}}, r_p};
        case (r_pk)
            3'd0:    pshift = pe;
            3'd1:    pshift = pe << 32;
            3'd2:    pshift = pe << 64;
            3'd3:    pshift = pe << 96;
            default: pshift = pe << 128;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= r_pv & r_plast;
            if (r_pv) begin
                r_acc <= r_acc + pshift;
            end
            if (i_start) begin
                r_x     <= i_op.from_acc ? r_acc : {{(AW-32){i_x[31]}}, i_x};
                if (i_op.clear) begin
                    r_acc <= '0;
                end
                r_m     <= i_m;
                r_nc    <= i_op.nc;
                r_sh    <= i_op.sh32;
                r_k     <= '0;
                r_issue <= 1'b1;
                r_pv    <= 1'b0;
            end else if (r_issue) begin
                r_p     <= xs * r_m;
                r_pk    <= {1'b0, r_k} + {2'b0, r_sh};
                r_pv    <= 1'b1;
                r_plast <= last_chunk;
                r_k     <= r_k + 2'd1;
                if (last_chunk) begin
                    r_issue <= 1'b0;
                end
            end else begin
                r_pv    <= 1'b0;
            end
        end
    end

    assign o_busy = r_issue | r_pv;
    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ----- rtl/cse_div.sv -----
// restoring divider, one quotient bit per cycle, remainder preloaded below the divisor
module cse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cse_pkg::DIV_W-1:0]   i_rem,
    input  logic [cse_pkg::QUO_W-1:0]   i_low,
    input  logic [cse_pkg::DIV_W-1:0]   i_div,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [cse_pkg::QUO_W-1:0]   o_quo
);

    localparam int DW = cse_pkg::DIV_W;
    localparam int QW = cse_pkg::QUO_W;

    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_d;
    logic [QW-1:0]          r_q;
    logic [$clog2(QW)-1:0]  r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [DW:0] rem2;
    logic        ge;

    always_comb begin
        rem2 = {r_rem, r_q[QW-1]};
        ge   = (rem2 >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse after the last quotient bit
            r_done <= ~i_start & r_busy & (r_cnt == '1);
            if (i_start) begin
                r_rem  <= i_rem;
                r_q    <= i_low;
                r_d    <= i_div;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? DW'(rem2 - {1'b0, r_d}) : rem2[DW-1:0];
                r_q   <= {r_q[QW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ----- rtl/cubic_spline_evaluator.sv -----
// cubic spline evaluator top level: knot table, search sequencer and arithmetic control
//
// Input stream (s side): tuser carries the opcode, tdata the knot or query fields.
// A load transfer writes one knot (x, y, second derivative) into the table at
// knot_index and gives no result; indexes beyond the table are dropped.
// An evaluate transfer scans the knot abscissae one entry at a time to find
// the interval, reads both end knots, forms the exact cubic numerator in a chunked
// 33x37 multiply-accumulate unit, then divides by 6*h*2^32 in a one-bit-per-cycle
// divider with rounding to nearest, ties away from zero, and saturation.
// Most of an evaluate's time goes to the multiply-accumulate sequence and the
// divider. One item is in work at a time; s_tready is high while idle.
// Results leave through an output register, so a new item is taken while the last
// result waits; a finished evaluate holds until that register is free.
// The knot count register resets to 2. It is written through i_cfg_wen and
// i_cfg_wdata; the user must do so only while the block is idle, which the
// block does not enforce. Reset clears control state; the knot table is not
// cleared and must be loaded before use.
module cubic_spline_evaluator #(
    parameter int MAX_KNOTS = cse_pkg::DEF_MAX_KNOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [4:0]   i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // knot_index[3:0], knot_x[35:4], knot_y[67:36], knot_second_derivative[99:68],
    // query_x[131:100], zero fill
    input  logic [135:0] i_s_tdata,
    // opcode[0]
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // spline_value[31:0], interval_used[35:32], zero fill
    output logic [39:0]  o_m_tdata,
    // saturated[0]
    output logic [0:0]   o_m_tuser
);

    localparam int IW  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW  = ($clog2(MAX_KNOTS + 1) > 5) ? $clog2(MAX_KNOTS + 1) : 5;
    localparam int AW  = cse_pkg::ACC_W;
    localparam int MW  = cse_pkg::MUL_W;
    localparam int DW  = cse_pkg::DIV_W;
    localparam int QW  = cse_pkg::QUO_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_SRD  = 12'b000000000010,
        S_SCMP = 12'b000000000100,
        S_RD0  = 12'b000000001000,
        S_RD1  = 12'b000000010000,
        S_GEO  = 12'b000000100000,
        S_PREP = 12'b000001000000,
        S_MAC  = 12'b000010000000,
        S_NORM = 12'b000100000000,
        S_CHK  = 12'b001000000000,
        S_DIV  = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } t_state;

    t_state          r_state;
    logic [4:0]      r_knots;
    logic [31:0]     r_q;
    logic [CW-1:0]   r_k;
    logic [CW-1:0]   r_i;
    cse_pkg::t_knot  r_e0;
    cse_pkg::t_knot  r_e1;
    logic [32:0]     r_h;
    logic [32:0]     r_a;
    logic [32:0]     r_b;
    cse_pkg::t_step  r_op;
    logic            r_go;
    logic [AW:0]     r_n;
    logic            r_neg;
    logic [DW-1:0]   r_d;
    logic [31:0]     r_val;
    logic            r_sat;
    logic            r_mvalid;
    logic [31:0]     r_out_val;
    logic [3:0]      r_out_int;
    logic            r_out_sat;

    // input fields
    logic [3:0]  in_idx;
    logic [31:0] in_x, in_y, in_g, in_q;
    logic        in_op;
    logic        s_fire;
    logic        m_fire;

    assign in_idx = i_s_tdata[3:0];
    assign in_x   = i_s_tdata[35:4];
    assign in_y   = i_s_tdata[67:36];
    assign in_g   = i_s_tdata[99:68];
    assign in_q   = i_s_tdata[131:100];
    assign in_op  = i_s_tuser[0];
    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire = i_s_tvalid & o_s_tready;
    assign m_fire = r_mvalid & i_m_tready;

    // effective knot count
    logic [CW-1:0] knw, n_eff, n_m1;
    always_comb begin
        knw = CW'(r_knots);
        if (knw < CW'(2)) begin
            n_eff = CW'(2);
        end else if (knw > CW'(MAX_KNOTS)) begin
            n_eff = CW'(MAX_KNOTS);
        end else begin
            n_eff = knw;
        end
        n_m1 = n_eff - CW'(1);
    end

    // knot table
    logic [CW-1:0]  ld_idx;
    logic [CW-1:0]  i_p1;
    logic           mem_we;
    logic [IW-1:0]  mem_raddr;
    cse_pkg::t_knot mem_wdata;
    cse_pkg::t_knot mem_rdata;

    assign ld_idx    = CW'(in_idx);
    assign i_p1      = r_i + CW'(1);
    assign mem_we    = s_fire & ~in_op & (ld_idx < CW'(MAX_KNOTS));
    assign mem_wdata = '{g: in_g, y: in_y, x: in_x};

    always_comb begin
        unique case (r_state)
            S_RD0:   mem_raddr = r_i[IW-1:0];
            S_RD1:   mem_raddr = i_p1[IW-1:0];
            default: mem_raddr = r_k[IW-1:0];
        endcase
    end

    cse_mem #(.DEPTH(MAX_KNOTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ld_idx[IW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // interval geometry
    logic [32:0] h_c, a_c, b_c;
    always_comb begin
        h_c = {r_e1.x[31], r_e1.x} - {r_e0.x[31], r_e0.x};
        a_c = {r_e1.x[31], r_e1.x} - {r_q[31], r_q};
        b_c = {r_q[31], r_q} - {r_e0.x[31], r_e0.x};
    end

    // multiply-accumulate operands
    logic [MW-1:0]    a37, b37, h37;
    logic [MW-1:0]    mac_m;
    logic [31:0]      mac_x;
    logic             mac_start;
    logic             mac_busy;
    logic             mac_done;
    logic [AW-1:0]    mac_acc;

    always_comb begin
        a37 = {{(MW-33){r_a[32]}}, r_a};
        b37 = {{(MW-33){r_b[32]}}, r_b};
        h37 = {{(MW-33){r_h[32]}}, r_h};
        case (r_op)
            cse_pkg::ST_G0: begin mac_m = a37 + h37;              mac_x = r_e0.g; end
            cse_pkg::ST_G1: begin mac_m = b37 + h37;              mac_x = r_e1.g; end
            cse_pkg::ST_MB: begin mac_m = b37;                    mac_x = '0;     end
            cse_pkg::ST_MA: begin mac_m = -a37;                   mac_x = '0;     end
            cse_pkg::ST_Y0: begin mac_m = (a37 << 2) + (a37 << 1); mac_x = r_e0.y; end
            default:        begin mac_m = (b37 << 2) + (b37 << 1); mac_x = r_e1.y; end
        endcase
    end

    assign mac_start = (r_state == S_MAC) & r_go;

    cse_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_op    (cse_pkg::step_op(r_op)),
        .i_x     (mac_x),
        .i_m     ($signed(mac_m)),
        .o_busy  (mac_busy),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    // rounding offset and divisor
    logic [32:0]   hm;
    logic [34:0]   hm3;
    logic [AW-1:0] acc_abs;
    always_comb begin
        hm      = r_h[32] ? (33'd0 - r_h) : r_h;
        hm3     = {1'b0, hm, 1'b0} + {2'b0, hm};
        acc_abs = mac_acc[AW-1] ? ('0 - mac_acc) : mac_acc;
    end

    // divider
    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [QW-1:0] div_quo;
    logic          big;

    assign big       = (r_n[AW:64] >= (AW-63)'(r_d));
    assign div_start = (r_state == S_CHK) & ~big;

    cse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (r_n[64+DW-1:64]),
        .i_low   (r_n[63:32]),
        .i_div   (r_d),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    logic [31:0] limit;
    logic        q_over;
    logic [31:0] mag;
    assign limit  = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign q_over = (div_quo > limit);
    assign mag    = q_over ? limit : div_quo;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_knots  <= 5'd2;
            r_mvalid <= 1'b0;
            r_go     <= 1'b0;
            r_k      <= '0;
            r_i      <= '0;
            r_op     <= cse_pkg::ST_G0;
        end else begin
            if (i_cfg_wen) begin
                r_knots <= i_cfg_wdata;
            end
            // the finish state reloads the result register itself
            if (m_fire && (r_state != S_FIN)) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire && in_op) begin
                        r_q     <= in_q;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= (r_k >= n_m1) ? S_RD0 : S_SCMP;
                end
                S_SCMP: begin
                    if ($signed(r_q) > $signed(mem_rdata.x)) begin
                        r_i     <= r_k;
                        r_k     <= r_k + CW'(1);
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_e0    <= mem_rdata;
                    r_state <= S_GEO;
                end
                S_GEO: begin
                    r_e1    <= mem_rdata;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_h <= h_c;
                    r_a <= a_c;
                    r_b <= b_c;
                    if (h_c == '0) begin
                        // coincident knots give the left ordinate
                        r_val   <= r_e0.y;
                        r_sat   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_op    <= cse_pkg::ST_G0;
                        r_go    <= 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_done && (r_op == cse_pkg::ST_Y1)) begin
                        r_go    <= 1'b0;
                        r_state <= S_NORM;
                    end else if (mac_done) begin
                        r_op <= cse_pkg::next_step(r_op);
                        r_go <= 1'b1;
                    end else begin
                        r_go <= 1'b0;
                    end
                end
                S_NORM: begin
                    r_n     <= {1'b0, acc_abs} + ((AW+1)'(hm3) << 32);
                    r_neg   <= mac_acc[AW-1] ^ r_h[32];
                    r_d     <= {hm3, 1'b0};
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (big) begin
                        r_val   <= r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        r_sat   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_val   <= r_neg ? (32'd0 - mag) : mag;
                        r_sat   <= q_over;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_mvalid || i_m_tready) begin
                        r_mvalid  <= 1'b1;
                        r_out_val <= r_val;
                        r_out_int <= r_i[3:0];
                        r_out_sat <= r_sat;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = {4'b0, r_out_int, r_out_val};
    assign o_m_tuser  = r_out_sat;

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |-> (!mac_busy && !div_busy))
        else $error("input transfer taken while arithmetic units busy");

    a_interval_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> (r_i < n_m1))
        else $error("interval beyond last knot pair");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_FIN))
        else $error("result register loaded outside finish");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

endmodule

// ----- sim/cubic_spline_evaluator_chk.sv -----
// checker for the cubic spline evaluator: knot table copy, result prediction and compare
module cubic_spline_evaluator_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [4:0]   i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic [0:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [39:0]  i_m_tdata,
    input  logic [0:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results,
    output int           o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  interval;
        logic        sat;
    } spline_result_t;

    logic signed [31:0] knot_x [16];
    logic signed [31:0] knot_y [16];
    logic signed [31:0] knot_g [16];
    logic [4:0]         knot_count = 5'd2;
    spline_result_t     expected_q [$];

    initial begin
        o_fail_count = 0;
        o_results    = 0;
        o_saturated  = 0;
    end

    assign o_pending = expected_q.size();

    function automatic spline_result_t predict_spline(input logic signed [31:0] q);
        int                  n;
        int                  i;
        logic signed [199:0] qw, x0, x1, h, a, b, num, mag, hm, quo, limit;
        logic                neg;
        spline_result_t      r;
        n = (knot_count < 2) ? 2 : (knot_count > 16) ? 16 : int'(knot_count);
        i = 0;
        if (q > knot_x[0])
            while (i + 1 < n - 1 && q > knot_x[i + 1])
                i++;
        r.interval = i[3:0];
        qw = q;
        x0 = knot_x[i];
        x1 = knot_x[i + 1];
        h = x1 - x0;
        if (h == 0) begin
            r.value = knot_y[i];
            r.sat = 1'b0;
            return r;
        end
        a = x1 - qw;
        b = qw - x0;
        // exact numerator of the cubic, linear part weighted by 6 * 2^32
        num = -(a * b * (200'(knot_g[i]) * (a + h) + 200'(knot_g[i + 1]) * (b + h)))
              + (((200'(knot_y[i]) * a + 200'(knot_y[i + 1]) * b) * 6) <<< 32);
        neg = (num < 0) ^ (h < 0);
        mag = (num < 0) ? -num : num;
        hm = (h < 0) ? -h : h;
        quo = (mag + ((3 * hm) <<< 32)) / ((6 * hm) <<< 32);
        limit = neg ? 200'sh80000000 : 200'sh7fffffff;
        r.sat = (quo > limit);
        if (r.sat)
            quo = limit;
        quo = neg ? -quo : quo;
        r.value = quo[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        spline_result_t got;
        spline_result_t want;
        if (!i_rst_n) begin
            knot_count <= 5'd2;
            expected_q.delete();
        end else begin
            if (i_cfg_wen)
                knot_count <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_LOAD) begin
                    knot_x[i_s_tdata[3:0]] = i_s_tdata[35:4];
                    knot_y[i_s_tdata[3:0]] = i_s_tdata[67:36];
                    knot_g[i_s_tdata[3:0]] = i_s_tdata[99:68];
                end else begin
                    expected_q.push_back(predict_spline(i_s_tdata[131:100]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata[31:0];
                got.interval = i_m_tdata[35:32];
                got.sat = i_m_tuser[0];
                o_results++;
                if (got.sat)
                    o_saturated++;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result transfer: value %h interval %0d sat %b",
                                 got.value, got.interval, got.sat);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected value %h interval %0d sat %b, got %h %0d %b",
                                     want.value, want.interval, want.sat,
                                     got.value, got.interval, got.sat);
                    end
                end
            end
        end
    end

endmodule

// ----- sim/cubic_spline_evaluator_tb.sv -----
// testbench top for the cubic spline evaluator: stimulus, handshake idling and verdict
module cubic_spline_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_EVAL   = 1'b1;
    localparam int   MAX_CYCLES = 2000000;
    localparam int   SETTLE     = 200;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [4:0]   i_cfg_wdata = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata = '0;
    logic [0:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [39:0]  o_m_tdata;
    logic [0:0]   o_m_tuser;

    int fail_count, pending, results, saturated;
    int cycles = 0;
    int loads_sent = 0;
    int evals_sent = 0;
    int rx_count = 0;
    bit no_idle = 1'b0;
    bit held = 1'b0;
    logic signed [31:0] table_x [16];

    cubic_spline_evaluator dut (.*);

    cubic_spline_evaluator_chk chk (
        .i_clk, .i_rst_n, .i_cfg_wen, .i_cfg_wdata,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results),
        .o_saturated(saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("cubic_spline_evaluator test failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (rx_count == 150 && !held) begin
                stall = 600;
                held = 1'b1;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            rx_count++;
        end
    end

    task automatic send_item(input logic op, input logic [3:0] idx, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] g,
                             input logic [31:0] q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {4'b0, q, g, y, x, idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (op == OP_LOAD) begin
            loads_sent++;
            table_x[idx] = x;
        end else begin
            evals_sent++;
        end
    endtask

    task automatic load_knot(input logic [3:0] idx, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] g);
        send_item(OP_LOAD, idx, x, y, g, $urandom);
    endtask

    task automatic evaluate_at(input logic [31:0] q);
        send_item(OP_EVAL, 4'($urandom), $urandom, $urandom, $urandom, q);
    endtask

    // block idle: nothing outstanding and the last item fully drained
    task automatic settle();
        i_s_tvalid <= 1'b0;
        // let the checker see the last transfer first
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_knot_count(input logic [4:0] n);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // sorted, unsorted or partly repeated knot abscissae with random content
    task automatic load_table(input int shape);
        logic signed [31:0] x;
        int k;
        x = $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
        for (k = 0; k < 16; k++) begin
            case (shape)
                0: begin
                    load_knot(4'(k), x, $signed($urandom_range(0, 1 << 25)) - (1 << 24),
                              $signed($urandom_range(0, 1 << 23)) - (1 << 22));
                    x = x + $urandom_range(1, 1 << 20);
                end
                1: load_knot(4'(k), $urandom, $urandom, $urandom);
                default: begin
                    load_knot(4'(k), x, $signed($urandom_range(0, 1 << 25)) - (1 << 24),
                              $urandom);
                    if ($urandom_range(0, 2) != 0)
                        x = x + $urandom_range(1, 1 << 16);
                end
            endcase
        end
    endtask

    function automatic logic [31:0] pick_query(input int n);
        logic signed [31:0] lo, hi, span;
        lo = table_x[0];
        hi = table_x[(n - 1) & 15];
        span = hi - lo;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return table_x[$urandom_range(0, 15)];
            2: return table_x[$urandom_range(0, 15)] + 1;
            default: begin
                if (span <= 0)
                    return lo + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                return lo - (span >>> 3) + $urandom_range(0, span + (span >>> 2));
            end
        endcase
    endfunction

    initial begin
        logic [4:0] n_cfg;
        int n_eff;
        int phase;
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset knot count of two
        for (k = 0; k < 16; k++)
            load_knot(4'(k), k << 16, (k * 3) << 16, (k - 8) << 12);
        evaluate_at(32'h8000_0000);
        evaluate_at(32'h7fff_ffff);
        evaluate_at(32'h0000_0000);
        evaluate_at(32'h0000_8000);
        evaluate_at(32'h0001_0000);
        load_knot(0, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        load_knot(1, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
        evaluate_at(32'h7fff_ffff);
        evaluate_at(32'h8000_0000);
        load_knot(1, 32'h0000_0000, 32'h1234_5678, 32'h0);
        evaluate_at(32'h0000_4000);
        evaluate_at(32'hffff_ffff);

        for (phase = 0; phase < 14; phase++) begin
            settle();
            case (phase)
                0: n_cfg = 5'd16;
                1: n_cfg = 5'd2;
                2: n_cfg = 5'd0;
                3: n_cfg = 5'd31;
                4: n_cfg = 5'd1;
                5: n_cfg = 5'd17;
                default: n_cfg = 5'($urandom_range(2, 16));
            endcase
            write_knot_count(n_cfg);
            n_eff = (n_cfg < 2) ? 2 : (n_cfg > 16) ? 16 : n_cfg;
            no_idle = (phase % 4 == 3);
            load_table(phase % 5 == 4 ? 1 : (phase % 5 == 2 ? 2 : 0));
            for (k = 0; k < 55; k++) begin
                if ($urandom_range(0, 19) == 0)
                    load_knot(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
                evaluate_at(pick_query(n_eff));
            end
        end
        no_idle = 1'b0;
        settle();

        $display("sent %0d knot loads and %0d evaluations over 14 knot-count settings",
                 loads_sent, evals_sent);
        $display("checked %0d results, %0d of them clipped", results, saturated);
        if (fail_count == 0)
            $display("cubic_spline_evaluator test passed");
        else
            $display("cubic_spline_evaluator test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cse_pkg.sv
rtl/cse_mem.sv
rtl/cse_mac.sv
rtl/cse_div.sv
rtl/cubic_spline_evaluator.sv
sim/cubic_spline_evaluator_chk.sv
sim/cubic_spline_evaluator_tb.sv
